FILE: rtl/wvavg_pkg.sv
package wvavg_pkg;

	// Sizing
	localparam int MAX_ELEMENTS = 1024;
	localparam int MAX_VECTORS  = 256;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int LEN_W        = 11;
	localparam int TALLY_W      = $clog2(MAX_VECTORS + 1);
	localparam int CNT_IN_W     = 21;
	localparam int COUNT_W      = CNT_IN_W - 1;
	localparam int VALUE_W      = 32;
	localparam int PROD_W       = COUNT_W + 1 + VALUE_W;
	localparam int SUM_W        = 61;
	localparam int TOTAL_W      = 29;
	localparam int NUM_W        = SUM_W + 1;
	localparam int DEN_W        = TOTAL_W + 1;
	localparam int STEP_W       = $clog2(NUM_W + 1);

	// Request kinds
	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_HEADER  = 2'd1,
		ACT_ELEMENT = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	// Result status, smaller nonzero code has priority
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_LEN    = 3'd1,
		ST_NEG_COUNT  = 3'd2,
		ST_ZERO_TOTAL = 3'd3,
		ST_TOO_MANY   = 3'd4
	} status_t;

	// Top level sequencer
	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_FETCH,
		S_DIV,
		S_FIN
	} ctl_state_t;

	// Divider sequencer
	typedef enum logic [1:0] {
		D_IDLE,
		D_PREP,
		D_RUN,
		D_DONE
	} div_state_t;

	// Keep the smallest nonzero code
	function automatic status_t merge_status(input status_t cur, input status_t code);
		if (cur == ST_OK || code < cur) begin
			return code;
		end
		return cur;
	endfunction

endpackage

FILE: rtl/wvavg_div.sv
module wvavg_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [wvavg_pkg::SUM_W-1:0]    sum,
	input  logic [wvavg_pkg::TOTAL_W-1:0]         total,
	output logic                                  done,
	output logic signed [wvavg_pkg::VALUE_W-1:0]  avg
);
	import wvavg_pkg::*;

	div_state_t            state_q, state_d;
	logic                  neg_q;
	logic [SUM_W-1:0]      mag_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [NUM_W-1:0]      quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [DEN_W:0]        shifted;
	logic                  fits;
	logic [DEN_W:0]        diff;

	// Restoring divide step: one quotient bit per cycle
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	// Next state
	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					state_d = D_PREP;
				end
			end
			D_PREP: state_d = D_RUN;
			D_RUN: begin
				if (step_q == STEP_W'(1)) begin
					state_d = D_DONE;
				end
			end
			D_DONE: begin
				done    = 1'b1;
				state_d = D_IDLE;
			end
			default: state_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == D_PREP) begin
				step_q <= STEP_W'(NUM_W);
			end else if (state_q == D_RUN) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// Datapath: magnitude, rounding bias, shift-subtract
	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= sum[SUM_W-1];
					mag_q <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
					den_q <= {total, 1'b0};
				end
			end
			D_PREP: begin
				quo_q <= {mag_q, 1'b0} + NUM_W'(den_q[DEN_W-1:1]);
				rem_q <= '0;
			end
			D_RUN: begin
				rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	// Apply sign and saturate to the Q16.16 range
	always_comb begin
		if (neg_q) begin
			if ((|quo_q[NUM_W-1:VALUE_W]) || (quo_q[VALUE_W-1] && (|quo_q[VALUE_W-2:0]))) begin
				avg = {1'b1, {(VALUE_W-1){1'b0}}};
			end else begin
				avg = -$signed(quo_q[VALUE_W-1:0]);
			end
		end else begin
			if (|quo_q[NUM_W-1:VALUE_W-1]) begin
				avg = {1'b0, {(VALUE_W-1){1'b1}}};
			end else begin
				avg = $signed(quo_q[VALUE_W-1:0]);
			end
		end
	end

endmodule

FILE: rtl/weighted_vector_average.sv
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   action, num_samples, vector_len,
//                                            element_value, read_index
// out       source     out_valid / out_ready average, status
//
// Start and header requests complete on acceptance; element requests for an
// open vector add an accumulate state (product and store read, then accumulate
// write). Reads go through a fetch state, the 62-step shift-subtract divider
// and a finish state; reads that end in an error status skip to it. Reset
// clears all bookkeeping; the sum store is not cleared, since every entry a
// read can reach is rewritten by the first vector of a batch. A read waits in
// its last state while a previous result is still held on the out channel.
module weighted_vector_average (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             action,
	input  logic signed [wvavg_pkg::CNT_IN_W-1:0]  num_samples,
	input  logic [wvavg_pkg::LEN_W-1:0]            vector_len,
	input  logic signed [wvavg_pkg::VALUE_W-1:0]   element_value,
	input  logic [wvavg_pkg::ADDR_W-1:0]           read_index,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [wvavg_pkg::VALUE_W-1:0]   average,
	output logic [2:0]                             status
);
	import wvavg_pkg::*;

	ctl_state_t              state_q, state_d;
	logic                    accept;
	action_t                 act;

	// Batch bookkeeping
	logic [TOTAL_W-1:0]      total_q;
	logic [TALLY_W-1:0]      tally_q;
	logic [LEN_W-1:0]        blen_q;
	logic [LEN_W-1:0]        pos_q;
	logic [COUNT_W-1:0]      count_q;
	status_t                 err_q;

	// Header and read evaluation
	status_t                 hdr_err;
	logic [LEN_W-1:0]        hdr_blen;
	logic [COUNT_W-1:0]      hdr_count;
	logic                    hdr_bump;
	logic                    elem_ok;
	status_t                 rd_status;

	// Sum store
	logic [SUM_W-1:0]        store_mem [MAX_ELEMENTS];
	logic [ADDR_W-1:0]       rd_addr;
	logic [SUM_W-1:0]        rd_data_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0]       acc_addr_q;
	logic                    acc_first_q;
	logic                    acc_wen_q;
	logic                    mem_we;
	logic [SUM_W-1:0]        wr_data;

	// Divider and result
	logic                    div_start;
	logic                    div_done;
	logic signed [VALUE_W-1:0] div_avg;
	logic signed [VALUE_W-1:0] res_avg_q;
	status_t                 res_status_q;
	logic                    out_load;
	logic                    out_valid_q;
	logic signed [VALUE_W-1:0] average_q;
	status_t                 status_q;

	assign act    = action_t'(action);
	assign accept = in_valid && in_ready;

	// Evaluate a header against the batch
	always_comb begin
		hdr_err   = err_q;
		hdr_blen  = blen_q;
		hdr_count = num_samples[CNT_IN_W-1] ? '0 : num_samples[COUNT_W-1:0];
		hdr_bump  = 1'b1;
		if (tally_q != '0 && pos_q != blen_q) begin
			hdr_err = merge_status(hdr_err, ST_BAD_LEN);
		end
		if (tally_q == '0) begin
			hdr_blen = vector_len;
		end else if (vector_len != blen_q) begin
			hdr_err = merge_status(hdr_err, ST_BAD_LEN);
		end
		if (vector_len == '0 || vector_len > LEN_W'(MAX_ELEMENTS)) begin
			hdr_err = merge_status(hdr_err, ST_BAD_LEN);
		end
		if (num_samples[CNT_IN_W-1]) begin
			hdr_err = merge_status(hdr_err, ST_NEG_COUNT);
		end
		if (tally_q >= TALLY_W'(MAX_VECTORS)) begin
			hdr_err   = merge_status(hdr_err, ST_TOO_MANY);
			hdr_count = '0;
			hdr_bump  = 1'b0;
		end
	end

	// Element needs an open vector with room left
	assign elem_ok = (tally_q != '0) && (pos_q < blen_q);

	// Status of a read request
	always_comb begin
		rd_status = err_q;
		if (tally_q != '0 && pos_q != blen_q) begin
			rd_status = merge_status(rd_status, ST_BAD_LEN);
		end else if ({1'b0, read_index} >= blen_q) begin
			rd_status = merge_status(rd_status, ST_BAD_LEN);
		end else if (total_q == '0) begin
			rd_status = merge_status(rd_status, ST_ZERO_TOTAL);
		end
	end

	// Sequencer
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (act == ACT_ELEMENT && elem_ok) begin
						state_d = S_ACC;
					end else if (act == ACT_READ) begin
						state_d = (rd_status == ST_OK) ? S_FETCH : S_FIN;
					end
				end
			end
			S_ACC: begin
				mem_we  = acc_wen_q;
				state_d = S_IDLE;
			end
			S_FETCH: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Update batch bookkeeping on accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tally_q <= '0;
			blen_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
			err_q   <= ST_OK;
		end else if (accept) begin
			unique case (act)
				ACT_START: begin
					total_q <= '0;
					tally_q <= '0;
					blen_q  <= '0;
					pos_q   <= '0;
					count_q <= '0;
					err_q   <= ST_OK;
				end
				ACT_HEADER: begin
					err_q   <= hdr_err;
					blen_q  <= hdr_blen;
					count_q <= hdr_count;
					total_q <= total_q + TOTAL_W'(hdr_count);
					pos_q   <= '0;
					if (hdr_bump) begin
						tally_q <= tally_q + TALLY_W'(1);
					end
				end
				ACT_ELEMENT: begin
					if (elem_ok) begin
						pos_q <= pos_q + LEN_W'(1);
					end else begin
						err_q <= merge_status(err_q, ST_BAD_LEN);
					end
				end
				ACT_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Form the weighted product and note where it goes
	always_ff @(posedge clk) begin
		if (accept && act == ACT_ELEMENT) begin
			prod_q      <= $signed({1'b0, count_q}) * element_value;
			acc_addr_q  <= pos_q[ADDR_W-1:0];
			acc_first_q <= tally_q == TALLY_W'(1);
			acc_wen_q   <= pos_q < LEN_W'(MAX_ELEMENTS);
		end
	end

	// Store port: overwrite on the first vector, accumulate after
	assign rd_addr = (act == ACT_ELEMENT) ? pos_q[ADDR_W-1:0] : read_index;
	assign wr_data = acc_first_q ? SUM_W'(prod_q)
	                             : rd_data_q + SUM_W'(prod_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[acc_addr_q] <= wr_data;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	wvavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    ($signed(rd_data_q)),
		.total  (total_q),
		.done   (div_done),
		.avg    (div_avg)
	);

	// Hold the pending result until the out channel is free
	always_ff @(posedge clk) begin
		if (accept && act == ACT_READ) begin
			res_avg_q    <= '0;
			res_status_q <= rd_status;
		end else if (state_q == S_DIV && div_done) begin
			res_avg_q    <= div_avg;
			res_status_q <= ST_OK;
		end
		if (out_load) begin
			average_q <= res_avg_q;
			status_q  <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign status    = status_q;

endmodule
